// File: hw/rtl/cei_pkg.sv
// cei_pkg: shared types and constants for the charge energy integrator.
// No dependencies.
package cei_pkg;

    localparam int SUM_BITS = 128;
    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [31:0] HALF_WORD    = 32'h8000_0000;
    localparam logic [31:0] MAX_POS      = 32'h7FFF_FFFF;
    localparam logic [7:0]  FLOOR_RST    = 8'd5;
    localparam logic [9:0]  SCALE_RST    = 10'd1000;
    localparam logic [31:0] DIVISOR_RST  = 32'd3600000000;

    localparam logic [1:0] REG_FLOOR   = 2'd0;
    localparam logic [1:0] REG_SCALE   = 2'd1;
    localparam logic [1:0] REG_DIVISOR = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_REC   = 2'd2,
        EV_END   = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture sample, decode
        logic mul_start; // product = I*V, then iterate ticks
        logic mul_step;
        logic div_start;
        logic div_step;
        logic commit;    // update sum / last sample, build result
        logic send;      // result accepted downstream
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic   active;  // previous sample has both nonzero
        logic   ended;   // previous sample both zero
        logic   charging;
        logic   step_done;
    } dp_stat_t;

endpackage

// File: hw/rtl/cei_datapath.sv
// cei_datapath: sample decode, bit-serial multiply, restoring divide, state.
// Depends on cei_pkg.
module cei_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cei_pkg::dp_cmd_t      cmd,
    output cei_pkg::dp_stat_t     stat,
    input  logic [31:0]           raw_current,
    input  logic [15:0]           raw_voltage,
    input  logic [31:0]           sample_time,
    input  logic [7:0]            current_floor,
    input  logic [9:0]            voltage_scale,
    input  logic [31:0]           energy_divisor,
    input  cei_pkg::event_t       ev,
    output logic [1:0]            event_res,
    output logic [63:0]           interval_energy,
    output logic [63:0]           energy_wh,
    output logic                  saturated
);
    localparam int SB = cei_pkg::SUM_BITS;
    localparam int CB = cei_pkg::CNT_BITS;

    logic [30:0] last_cur_reg;
    logic [25:0] last_volt_reg;
    logic [31:0] last_time_reg;
    logic        charging_reg;
    logic [SB-1:0] sum_reg;

    logic [30:0] new_cur_reg;
    logic [25:0] new_volt_reg;
    logic [31:0] new_time_reg;
    logic [31:0] ticks_reg;
    logic [31:0] div_reg;

    logic [SB-1:0] prod_reg;   // I*V shifted operand
    logic [SB-1:0] acc_reg;    // product accumulator
    logic [SB-1:0] quo_reg;
    logic [32:0]   rem_reg;
    logic [SB-1:0] dividend_reg;
    logic [CB-1:0] cnt_reg;

    logic [31:0] cur_fold;
    logic [31:0] cur_dec;
    logic [25:0] volt_dec;
    logic [SB-1:0] sum_new;
    logic [32:0] rem_sh;

    always_comb begin
        cur_fold = (raw_current > cei_pkg::MAX_POS) ? raw_current - cei_pkg::HALF_WORD
                                                    : cei_pkg::MAX_POS - raw_current;
        cur_dec  = (cur_fold < {24'd0, current_floor}) ? 32'd0 : cur_fold;
        volt_dec = 26'({10'd0, raw_voltage} * {16'd0, voltage_scale});
        sum_new  = sum_reg + acc_reg;
        rem_sh   = {rem_reg[31:0], dividend_reg[SB-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cur_reg  <= '0;
            last_volt_reg <= '0;
            last_time_reg <= '0;
            charging_reg  <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cmd.load) begin
                new_cur_reg  <= cur_dec[30:0];
                new_volt_reg <= volt_dec;
                new_time_reg <= sample_time;
                ticks_reg    <= sample_time - last_time_reg;
                div_reg      <= (energy_divisor == '0) ? 32'd1 : energy_divisor;
                acc_reg      <= '0;
            end
            if (cmd.mul_start) begin
                prod_reg <= SB'({31'd0, last_cur_reg} * {36'd0, last_volt_reg});
                cnt_reg  <= CB'(32);
            end else if (cmd.mul_step) begin
                if (ticks_reg[0]) acc_reg <= acc_reg + prod_reg;
                prod_reg  <= prod_reg << 1;
                ticks_reg <= ticks_reg >> 1;
                cnt_reg   <= cnt_reg - 1'b1;
            end
            if (cmd.div_start) begin
                dividend_reg <= (ev == cei_pkg::EV_REC) ? sum_new : sum_reg;
                rem_reg      <= '0;
                quo_reg      <= '0;
                cnt_reg      <= CB'(SB);
            end else if (cmd.div_step) begin
                if (rem_sh >= {1'b0, div_reg}) begin
                    rem_reg <= rem_sh - {1'b0, div_reg};
                    quo_reg <= {quo_reg[SB-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[SB-2:0], 1'b0};
                end
                dividend_reg <= dividend_reg << 1;
                cnt_reg      <= cnt_reg - 1'b1;
            end
            if (cmd.commit) begin
                case (ev)
                    cei_pkg::EV_START: begin
                        charging_reg <= 1'b1;
                        sum_reg      <= '0;
                    end
                    cei_pkg::EV_END:   charging_reg <= 1'b0;
                    cei_pkg::EV_REC:   sum_reg <= sum_new;
                    default: ;
                endcase
                last_cur_reg  <= new_cur_reg;
                last_volt_reg <= new_volt_reg;
                last_time_reg <= new_time_reg;
            end
        end
    end

    // output register, held until the word is taken
    logic sat_ie, sat_wh;
    always_comb begin
        sat_ie = |acc_reg[SB-1:64];
        sat_wh = |quo_reg[SB-1:64];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            event_res       <= ev;
            interval_energy <= '0;
            energy_wh       <= '0;
            saturated       <= 1'b0;
            if (ev == cei_pkg::EV_REC) begin
                interval_energy <= sat_ie ? '1 : acc_reg[63:0];
                energy_wh       <= sat_wh ? '1 : quo_reg[63:0];
                saturated       <= sat_ie | sat_wh;
            end else if (ev == cei_pkg::EV_END) begin
                energy_wh <= sat_wh ? '1 : quo_reg[63:0];
                saturated <= sat_wh;
            end
        end
    end

    always_comb begin
        stat.active    = (last_cur_reg != '0) && (last_volt_reg != '0);
        stat.ended     = (last_cur_reg == '0) && (last_volt_reg == '0);
        stat.charging  = charging_reg;
        stat.step_done = (cnt_reg == CB'(1));
    end

endmodule

// File: hw/rtl/cei_ctrl.sv
// cei_ctrl: sequencer for one sample: load, multiply and divide as the event needs, present.
// Depends on cei_pkg.
module cei_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  cei_pkg::dp_stat_t      stat,
    output cei_pkg::dp_cmd_t       cmd,
    output cei_pkg::event_t        ev
);
    cei_pkg::state_t state_reg, state_next;
    cei_pkg::event_t ev_reg, ev_next;
    logic            out_valid_reg, out_valid_next;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // decision on the previous sample, taken when a new word arrives
    cei_pkg::event_t ev_decide;
    always_comb begin
        ev_decide = cei_pkg::EV_NONE;
        if (stat.ended && stat.charging)        ev_decide = cei_pkg::EV_END;
        else if (stat.active && !stat.charging) ev_decide = cei_pkg::EV_START;
        else if (stat.active)                   ev_decide = cei_pkg::EV_REC;
    end

    logic in_mul_reg, in_div_reg;

    always_comb begin
        state_next = state_reg;
        ev_next    = ev_reg;
        case (state_reg)
            cei_pkg::ST_IDLE: if (accept) begin
                ev_next = ev_decide;
                case (ev_decide)
                    cei_pkg::EV_REC: state_next = cei_pkg::ST_MUL;
                    cei_pkg::EV_END: state_next = cei_pkg::ST_DIV;
                    default:         state_next = cei_pkg::ST_OUT;
                endcase
            end
            cei_pkg::ST_MUL: if (stat.step_done) state_next = cei_pkg::ST_DIV;
            cei_pkg::ST_DIV: if (stat.step_done && in_div_reg) state_next = cei_pkg::ST_OUT;
            cei_pkg::ST_OUT: state_next = cei_pkg::ST_IDLE;
            default:         state_next = cei_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_tready      = (state_reg == cei_pkg::ST_IDLE) && !out_valid_reg;
        cmd.load      = accept;
        cmd.mul_start = accept && (ev_decide == cei_pkg::EV_REC);
        cmd.mul_step  = (state_reg == cei_pkg::ST_MUL) && in_mul_reg;
        // first divide cycle: event and product sum are settled by now
        cmd.div_start = (state_reg == cei_pkg::ST_DIV) && !in_div_reg;
        cmd.div_step  = (state_reg == cei_pkg::ST_DIV) && in_div_reg;
        cmd.commit    = (state_reg == cei_pkg::ST_OUT);
        cmd.send      = m_tvalid && m_tready;
        ev            = ev_reg;
        m_tvalid      = out_valid_reg;
        out_valid_next = out_valid_reg;
        if (cmd.send)   out_valid_next = 1'b0;
        if (cmd.commit) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cei_pkg::ST_IDLE;
            ev_reg        <= cei_pkg::EV_NONE;
            out_valid_reg <= 1'b0;
            in_mul_reg    <= 1'b0;
            in_div_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ev_reg        <= ev_next;
            out_valid_reg <= out_valid_next;
            in_mul_reg    <= cmd.mul_start || (cmd.mul_step && !stat.step_done);
            in_div_reg    <= cmd.div_start || (cmd.div_step && !stat.step_done);
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cei_pkg::ST_IDLE) |-> !s_tready)
        else $error("input accepted while busy");
    a_commit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("result not presented after commit");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !out_valid_reg)
        else $error("result overwritten");
    a_div_follows_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cei_pkg::ST_MUL && stat.step_done) |=> state_reg == cei_pkg::ST_DIV)
        else $error("divide did not follow multiply");

endmodule

// File: hw/rtl/charge_energy_integrator_unit.sv
// charge_energy_integrator_unit: top level, APB registers and stream ports.
// Depends on cei_pkg, cei_ctrl, cei_datapath.
//
// Usage: meter samples enter on the s_ stream, one word each:
// s_tdata = {sample_time, raw_voltage, raw_current}. Every sample yields
// exactly one result word on the m_ stream.
// From the accepting edge to m_tvalid, a sample that records energy passes
// through the multiply, the divide setup, the divide and the commit; a
// session end passes through the divide setup, the divide and the commit;
// other samples go straight to the commit. The multiply is a bit-serial
// pass over the ticks and the divider yields one quotient bit per cycle.
// One sample is in flight at a time; s_tready stays low while working and
// while a result waits, and rises the cycle after the result is taken.
// A stalled receiver holds back the input.
// Reset (aresetn low, synchronous) returns to idle with zero state and the
// default register values; no clearing pass is needed.
// Registers over APB: 0x0 current_floor, 0x4 voltage_scale,
// 0x8 energy_divisor; write only while idle.
module charge_energy_integrator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // raw_current[31:0], raw_voltage[47:32], sample_time[79:48]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // event_res[1:0], interval_energy[65:2],
                                    // energy_wh[129:66], saturated[130], zero fill
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [7:0]  floor_reg;
    logic [9:0]  scale_reg;
    logic [31:0] div_reg;
    logic        wr;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr  = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= cei_pkg::FLOOR_RST;
            scale_reg <= cei_pkg::SCALE_RST;
            div_reg   <= cei_pkg::DIVISOR_RST;
        end else if (wr && paddr[1:0] == 2'b00) begin
            case (idx)
                cei_pkg::REG_FLOOR:   floor_reg <= pwdata[7:0];
                cei_pkg::REG_SCALE:   scale_reg <= pwdata[9:0];
                cei_pkg::REG_DIVISOR: div_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cei_pkg::REG_FLOOR:   prdata = {24'd0, floor_reg};
            cei_pkg::REG_SCALE:   prdata = {22'd0, scale_reg};
            cei_pkg::REG_DIVISOR: prdata = div_reg;
            default:              prdata = '0;
        endcase
    end

    cei_pkg::dp_cmd_t  cmd;
    cei_pkg::dp_stat_t stat;
    cei_pkg::event_t   ev;
    logic [1:0]  event_res;
    logic [63:0] interval_energy, energy_wh;
    logic        saturated;

    cei_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd), .ev(ev)
    );

    cei_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .raw_current(s_tdata[31:0]), .raw_voltage(s_tdata[47:32]),
        .sample_time(s_tdata[79:48]),
        .current_floor(floor_reg), .voltage_scale(scale_reg), .energy_divisor(div_reg),
        .ev(ev), .event_res(event_res), .interval_energy(interval_energy),
        .energy_wh(energy_wh), .saturated(saturated)
    );

    assign m_tdata = {5'd0, saturated, energy_wh, interval_energy, event_res};

endmodule
